// ===== hdl/dpm_pkg.sv =====
// Shared types and codes for the demand paging manager.
`default_nettype none

package dpm_pkg;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_MAP    = 2'd1,
    OP_FORK   = 2'd2
  } op_t;

  // Action codes of a result beat
  typedef enum logic [2:0] {
    ACT_HIT    = 3'd0,
    ACT_SWAPIN = 3'd1,
    ACT_COPY   = 3'd2,
    ACT_ZERO   = 3'd3,
    ACT_MAPPED = 3'd4,
    ACT_FORK   = 3'd5
  } act_t;

  // Frame allocator controls, qualified by the commit of one item
  typedef struct packed {
    logic take;
    logic free;
  } frame_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/demand_paging_manager.sv =====
// Demand paging manager top level: page table flags, fault resolution, result register.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   op, page, write, writable
//   out      output     out_valid/out_stall action, frame, copy_source, evicted,
//                                           evicted_page, swap_out
//
// One item per cycle sustained while out_stall is low; each beat passes the decision
// stage registers, then the result register (the page-to-frame memory read runs alongside
// the input capture, and the decision feeds the result register). Reset clears all page
// flags, the fill count, victim pointer and result valid at once; no clearing pass is
// needed. A stalled result holds the decision stage; in_stall rises only when that stage
// holds an item it cannot commit. Op code 3 produces no result beat and changes no state.
`default_nettype none

module demand_paging_manager #(
  parameter int PAGES  = 64,
  parameter int FRAMES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [5:0] in_page,
  input  wire logic       in_write,
  input  wire logic       in_writable,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_action,
  output logic [3:0]      out_frame,
  output logic [3:0]      out_copy_source,
  output logic            out_evicted,
  output logic [5:0]      out_evicted_page,
  output logic            out_swap_out
);
  import dpm_pkg::*;

  localparam int PW = $clog2(PAGES);
  localparam int FW = $clog2(FRAMES);

  // Decision stage registers
  logic          s1_valid_r;
  logic [1:0]    s1_op_r;
  logic [PW-1:0] s1_page_r;
  logic          s1_inrange_r;
  logic          s1_wr_r;
  logic          s1_writable_r;

  // Page flags
  logic [PAGES-1:0] pv_r, pv_nxt;
  logic [PAGES-1:0] pd_r, pd_nxt;
  logic [PAGES-1:0] pc_r, pc_nxt;
  logic [PAGES-1:0] pb_r, pb_nxt;

  // Result registers
  logic       out_valid_r;
  logic [2:0] out_action_r, out_action_nxt;
  logic [3:0] out_frame_r, out_frame_nxt;
  logic [3:0] out_copy_r, out_copy_nxt;
  logic       out_evicted_r, out_evicted_nxt;
  logic [5:0] out_evpage_r, out_evpage_nxt;
  logic       out_swap_r, out_swap_nxt;

  logic          accept;
  logic          advance;
  logic [FW-1:0] pf_rd;
  logic [FW-1:0] g_frame;
  logic [PW-1:0] g_owner;
  logic          g_evict;
  frame_ctrl_t   fctrl;

  logic cur_v, cur_c, cur_b;
  logic is_acc, is_map, is_fork, hit, fault, sel_swap, sel_copy, evict;

  // Handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r       <= in_op;
      s1_page_r     <= PW'(in_page);
      s1_inrange_r  <= (32'(in_page) < PAGES);
      s1_wr_r       <= in_write;
      s1_writable_r <= in_writable;
    end
  end

  // Current page flags and fault classification
  assign cur_v = pv_r[s1_page_r];
  assign cur_c = pc_r[s1_page_r];
  assign cur_b = pb_r[s1_page_r];

  assign is_acc   = (s1_op_r == OP_ACCESS) && s1_inrange_r;
  assign is_map   = (s1_op_r == OP_MAP) && s1_inrange_r;
  assign is_fork  = (s1_op_r == OP_FORK);
  assign hit      = cur_v && !(s1_wr_r && cur_c);
  assign fault    = is_acc && !hit;
  assign sel_swap = cur_b && !cur_v;
  assign sel_copy = !sel_swap && cur_c;
  assign evict    = fault && g_evict;

  // Allocator controls
  assign fctrl.take = advance && fault;
  assign fctrl.free = advance && ((fault && sel_copy) || (is_map && cur_v));

  dpm_pf_ram #(
    .DEPTH (PAGES),
    .WIDTH (FW)
  ) u_pf_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (PW'(in_page)),
    .wr_en   (advance && fault),
    .wr_addr (s1_page_r),
    .wr_data (g_frame),
    .rd_data (pf_rd)
  );

  dpm_frame_alloc #(
    .PAGES  (PAGES),
    .FRAMES (FRAMES)
  ) u_frame_alloc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (fctrl),
    .free_frame  (pf_rd),
    .new_owner   (s1_page_r),
    .grant_frame (g_frame),
    .grant_owner (g_owner),
    .grant_evict (g_evict)
  );

  // Next page flags: fork mark, then eviction of the owner, then the addressed page
  always_comb begin
    pv_nxt = pv_r;
    pd_nxt = pd_r;
    pc_nxt = pc_r;
    pb_nxt = pb_r;
    for (int i = 0; i < PAGES; i++) begin
      if (is_fork && pv_r[i]) begin
        pc_nxt[i] = 1'b1;
      end
      if (evict && (g_owner == PW'(i))) begin
        pv_nxt[i] = 1'b0;
        pb_nxt[i] = 1'b1;
      end
      if (s1_page_r == PW'(i)) begin
        if (is_acc) begin
          if (hit) begin
            if (s1_wr_r) begin
              pd_nxt[i] = 1'b1;
            end
          end else begin
            pv_nxt[i] = 1'b1;
            if (sel_swap) begin
              pd_nxt[i] = 1'b0;
            end else if (sel_copy) begin
              pd_nxt[i] = 1'b1;
              pc_nxt[i] = 1'b0;
            end else begin
              pd_nxt[i] = s1_wr_r;
            end
          end
        end else if (is_map) begin
          pv_nxt[i] = 1'b0;
          pd_nxt[i] = 1'b0;
          pc_nxt[i] = !s1_writable_r;
          pb_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      pd_r <= '0;
      pc_r <= '0;
      pb_r <= '0;
    end else if (advance) begin
      pv_r <= pv_nxt;
      pd_r <= pd_nxt;
      pc_r <= pc_nxt;
      pb_r <= pb_nxt;
    end
  end

  // Result fields
  always_comb begin
    out_action_nxt  = ACT_HIT;
    out_frame_nxt   = '0;
    out_copy_nxt    = '0;
    out_evicted_nxt = 1'b0;
    out_evpage_nxt  = '0;
    out_swap_nxt    = 1'b0;
    case (s1_op_r)
      OP_FORK: begin
        out_action_nxt = ACT_FORK;
      end
      OP_MAP: begin
        out_action_nxt = ACT_MAPPED;
      end
      OP_ACCESS: begin
        if (is_acc && hit) begin
          out_frame_nxt = 4'(pf_rd);
        end else if (fault) begin
          out_frame_nxt   = 4'(g_frame);
          out_evicted_nxt = evict;
          if (evict) begin
            out_evpage_nxt = 6'(g_owner);
            out_swap_nxt   = pd_r[g_owner];
          end
          if (sel_swap) begin
            out_action_nxt = ACT_SWAPIN;
          end else if (sel_copy) begin
            out_action_nxt = ACT_COPY;
            out_copy_nxt   = 4'(pf_rd);
          end else begin
            out_action_nxt = ACT_ZERO;
          end
        end
      end
      default: begin
        out_action_nxt = ACT_HIT;
      end
    endcase
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r && ((s1_op_r == OP_ACCESS) || (s1_op_r == OP_MAP) ||
                                    (s1_op_r == OP_FORK));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action_r  <= out_action_nxt;
      out_frame_r   <= out_frame_nxt;
      out_copy_r    <= out_copy_nxt;
      out_evicted_r <= out_evicted_nxt;
      out_evpage_r  <= out_evpage_nxt;
      out_swap_r    <= out_swap_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_frame        = out_frame_r;
  assign out_copy_source  = out_copy_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evpage_r;
  assign out_swap_out     = out_swap_r;

`ifndef SYNTHESIS
  // A dirty write-out only comes with an eviction
  a_swap_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_swap_out |-> out_evicted)
    else $error("swap_out without eviction");

  // Only a fault can evict
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |->
      (out_action == ACT_SWAPIN) || (out_action == ACT_COPY) || (out_action == ACT_ZERO))
    else $error("eviction reported on a non-fault result");

  // A copy source is reported only for a copy-on-write copy
  a_copy_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_COPY) |-> (out_copy_source == 4'd0))
    else $error("copy source on a non-copy result");

  // Input is held back only by an item that cannot commit
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked item");
`endif

endmodule

`default_nettype wire

// ===== hdl/dpm_pf_ram.sv =====
// Page-to-frame memory: one write port, one registered read port with write bypass.
`default_nettype none

module dpm_pf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write on commit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read on accept; take the word being written in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/dpm_frame_alloc.sv =====
// Frame allocator: fresh frames in index order, then FIFO victims with owner tracking.
`default_nettype none

module dpm_frame_alloc #(
  parameter int PAGES  = 64,
  parameter int FRAMES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dpm_pkg::frame_ctrl_t          ctrl,
  input  wire logic [$clog2(FRAMES)-1:0]     free_frame,
  input  wire logic [$clog2(PAGES)-1:0]      new_owner,
  output logic      [$clog2(FRAMES)-1:0]     grant_frame,
  output logic      [$clog2(PAGES)-1:0]      grant_owner,
  output logic                               grant_evict
);
  import dpm_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int PW = $clog2(PAGES);
  localparam int CW = $clog2(FRAMES + 1);

  logic [CW-1:0]     handed_r, handed_nxt;
  logic [FW-1:0]     victim_r, victim_nxt;
  logic [PW-1:0]     owner_r [FRAMES];
  logic [FRAMES-1:0] live_r, live_nxt;
  logic              fresh;

  // Pick a never-used frame first, else the FIFO victim
  assign fresh       = (handed_r < CW'(FRAMES));
  assign grant_frame = fresh ? FW'(handed_r) : victim_r;
  assign grant_owner = owner_r[victim_r];
  assign grant_evict = !fresh && live_r[victim_r];

  // Advance the fill count or the victim pointer; track live ownership
  always_comb begin
    handed_nxt = handed_r;
    victim_nxt = victim_r;
    live_nxt   = live_r;
    if (ctrl.free) begin
      live_nxt[free_frame] = 1'b0;
    end
    if (ctrl.take) begin
      live_nxt[grant_frame] = 1'b1;
      if (fresh) begin
        handed_nxt = handed_r + 1'b1;
      end else if (victim_r == FW'(FRAMES - 1)) begin
        victim_nxt = '0;
      end else begin
        victim_nxt = victim_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      handed_r <= '0;
      victim_r <= '0;
      live_r   <= '0;
    end else begin
      handed_r <= handed_nxt;
      victim_r <= victim_nxt;
      live_r   <= live_nxt;
    end
  end

  // Record the new owner of a taken frame
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      owner_r[grant_frame] <= new_owner;
    end
  end

endmodule

`default_nettype wire
